[rtl/path_extension_rewrite_top_assert.svh]
`ifndef PATH_EXTENSION_REWRITE_TOP_ASSERT_SVH
`define PATH_EXTENSION_REWRITE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PXR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pxr check failed");

// next-cycle implication, checked outside reset
`define PXR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pxr check failed");

`endif

[rtl/pxr_pkg.sv]
package pxr_pkg;

  localparam int WinDepth = 4;
  localparam int MaxOut   = 5;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] fill_t;
  typedef byte_t [WinDepth-1:0] win_t;

  typedef struct packed {
    byte_t [MaxOut-1:0] bytes;
    fill_t              count;
    logic               has_last;
  } req_t;

  localparam byte_t ChDot   = 8'h2E;
  localparam byte_t ChSlash = 8'h2F;
  localparam byte_t ChBack  = 8'h5C;
  localparam byte_t ChC     = 8'h63;
  localparam byte_t ChO     = 8'h6F;
  localparam byte_t ChM     = 8'h6D;
  localparam byte_t ChE     = 8'h65;
  localparam byte_t ChX     = 8'h78;
  localparam byte_t ChD     = 8'h64;
  localparam byte_t ChL     = 8'h6C;
  localparam byte_t ChS     = 8'h73;
  localparam byte_t ChH     = 8'h68;
  localparam byte_t ChZero  = 8'h30;
  localparam byte_t ChOne   = 8'h31;
  localparam byte_t ChThree = 8'h33;
  localparam byte_t ChFive  = 8'h35;

  localparam fill_t FillFull = 3'd4;
  localparam fill_t FillSh   = 3'd3;

  function automatic win_t rewrite_tail(win_t w, fill_t fill);
    win_t r;
    r = w;
    if (fill == FillFull && w[0] == ChDot && w[1] == ChC && w[2] == ChO && w[3] == ChM) begin
      r[2] = ChZero;
    end else if (fill == FillFull && w[0] == ChDot && w[1] == ChE && w[2] == ChX &&
                 w[3] == ChE) begin
      r[3] = ChThree;
    end else if (fill == FillFull && w[0] == ChDot && w[1] == ChD && w[2] == ChL &&
                 w[3] == ChL) begin
      r[3] = ChOne;
    end else if (fill == FillSh && w[0] == ChDot && w[1] == ChS && w[2] == ChH) begin
      r[1] = ChFive;
    end else if (fill == FillFull && w[1] == ChDot && w[2] == ChS && w[3] == ChH) begin
      r[2] = ChFive;
    end
    return r;
  endfunction

endpackage

[rtl/pxr_front.sv]
module pxr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pxr_pkg::byte_t path_byte,
  input  logic          end_of_path,
  input  logic          q_full,
  output logic          enq,
  output pxr_pkg::req_t enq_req
);

  pxr_pkg::win_t  tail_window;
  pxr_pkg::fill_t window_fill;
  pxr_pkg::win_t  w1, w2, w3;
  pxr_pkg::fill_t f2;
  logic           accept, is_sep;

  assign accept = push && !q_full;
  assign is_sep = (path_byte == pxr_pkg::ChSlash) || (path_byte == pxr_pkg::ChBack);

  always_comb begin
    w1 = is_sep ? pxr_pkg::rewrite_tail(tail_window, window_fill) : tail_window;
    w2 = w1;
    f2 = window_fill + 3'd1;
    if (window_fill == pxr_pkg::FillFull) begin
      w2 = {path_byte, w1[3], w1[2], w1[1]};
      f2 = pxr_pkg::FillFull;
    end else begin
      w2[window_fill[1:0]] = path_byte;
    end
    w3 = pxr_pkg::rewrite_tail(w2, f2);

    enq_req          = '0;
    enq_req.has_last = end_of_path;
    if (window_fill == pxr_pkg::FillFull) begin
      enq_req.bytes[0] = w1[0];
      if (end_of_path) begin
        enq_req.bytes[4:1] = w3;
        enq_req.count      = 3'd5;
      end else begin
        enq_req.count = 3'd1;
      end
    end else begin
      enq_req.bytes[3:0] = w3;
      enq_req.count      = f2;
    end
    enq = accept && ((window_fill == pxr_pkg::FillFull) || end_of_path);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
    end else if (accept) begin
      window_fill <= end_of_path ? 3'd0 : f2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tail_window <= w2;
    end
  end

endmodule

[rtl/pxr_queue.sv]
module pxr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          enq,
  input  pxr_pkg::req_t enq_req,
  output logic          q_full,
  input  logic          deq,
  output pxr_pkg::req_t head,
  output logic          q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pxr_pkg::req_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= enq_req;
    end
  end

endmodule

[rtl/pxr_back.sv]
module pxr_back (
  input  logic          clk,
  input  logic          rst,
  input  pxr_pkg::req_t head,
  input  logic          q_empty,
  output logic          deq,
  output logic          empty,
  input  logic          pop,
  output pxr_pkg::byte_t out_byte,
  output logic          last_out
);

  pxr_pkg::fill_t idx;
  logic           out_valid, load, last_idx;

  assign empty    = !out_valid;
  assign load     = !out_valid || pop;
  assign last_idx = (idx == head.count - 3'd1);
  assign deq      = load && !q_empty && last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= last_idx ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_byte <= head.bytes[idx];
      last_out <= head.has_last && last_idx;
    end
  end

endmodule

[rtl/path_extension_rewrite_top.sv]
// channel   handshake     payload
// input     push / full   path_byte[7:0], end_of_path
// result    pop / empty   out_byte[7:0], last_out
//
// one byte per cycle in unless full, out when popped; a result passes the
// queue and result register after a byte pushes it out of the four-byte window
// the last byte of a path flushes up to five bytes, drained one per cycle
// by the result stage on pop; full rises only while the request queue is full
// rst is synchronous and clears window, queue and result stage
module path_extension_rewrite_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] path_byte,
  input  logic       end_of_path,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       last_out
);

  `include "path_extension_rewrite_top_assert.svh"

  logic          enq, deq, q_full, q_empty;
  pxr_pkg::req_t enq_req, head;

  assign full = q_full;

  pxr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .path_byte   (path_byte),
    .end_of_path (end_of_path),
    .q_full      (q_full),
    .enq         (enq),
    .enq_req     (enq_req)
  );

  pxr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_req (enq_req),
    .q_full  (q_full),
    .deq     (deq),
    .head    (head),
    .q_empty (q_empty)
  );

  pxr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .deq      (deq),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last_out (last_out)
  );

  `PXR_ASSERT_NOW(a_no_enq_when_full, q_full, !enq)
  `PXR_ASSERT_NOW(a_no_deq_when_empty, q_empty, !deq)
  `PXR_ASSERT_NEXT(a_flush_queued, push && !full && end_of_path, !q_empty)

endmodule
